@@ rtl/mrii_pkg.sv @@
// ----------------------------------------------------------------------------
// mrii_pkg: shared types and constants for the mixed-radix index iterator
// Item layouts, opcodes, status codes, register indexes and sizing.
// ----------------------------------------------------------------------------
package mrii_pkg;

  localparam int MAX_DIMS = 4;
  localparam int DIGIT_W  = 16;
  localparam int LIN_W    = 64;
  localparam int POS_W    = 2;
  localparam int CNT_W    = 3;
  localparam int OP_W     = 2;
  localparam int ST_W     = 3;
  localparam int BIT_W    = $clog2(DIGIT_W);
  localparam int REG_W    = 3;

  // opcodes
  localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
  localparam logic [OP_W-1:0] OP_NEXT    = 2'd1;
  localparam logic [OP_W-1:0] OP_REVERSE = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FINISHED = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [ST_W-1:0] ST_ZERO_DIM = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

  // register indexes
  localparam logic [REG_W-1:0] REG_DIM_COUNT = 3'd0;
  localparam logic [REG_W-1:0] REG_DIM_SIZE0 = 3'd1;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [LIN_W-1:0] linear_index;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic [ST_W-1:0]    status;
  } res_t;

  // configuration as seen by the sequencer
  typedef struct packed {
    logic [CNT_W-1:0]                n;
    logic [MAX_DIMS-1:0][DIGIT_W-1:0] sizes;
    logic                            zero;
  } cfg_view_t;

endpackage

@@ rtl/mrii_alu.sv @@
// ----------------------------------------------------------------------------
// mrii_alu: shared shift and add/subtract unit
// Computes a + (b << sh) or a - (b << sh); carry is no-borrow on subtract.
// ----------------------------------------------------------------------------
module mrii_alu
  import mrii_pkg::*;
(
  input  logic [LIN_W-1:0] a,
  input  logic [LIN_W-1:0] b,
  input  logic [BIT_W-1:0] sh,
  input  logic             sub,
  output logic [LIN_W-1:0] sum,
  output logic             carry
);

  logic [LIN_W-1:0] b_sh;
  logic [LIN_W-1:0] b_op;
  logic [LIN_W:0]   full;

  assign b_sh  = b << sh;
  assign b_op  = sub ? ~b_sh : b_sh;
  assign full  = {1'b0, a} + {1'b0, b_op} + {{LIN_W{1'b0}}, sub};
  assign sum   = full[LIN_W-1:0];
  assign carry = full[LIN_W];

endmodule

@@ rtl/mrii_seq.sv @@
// ----------------------------------------------------------------------------
// mrii_seq: command sequencer
// Odometer state, stride products, serial digit extraction, result register.
// ----------------------------------------------------------------------------
module mrii_seq
  import mrii_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_view_t cfg,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_t      cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_t      res
);

  typedef enum logic [2:0] {
    S_IDLE, S_STATUS, S_NEXT, S_MUL, S_RANGE, S_DIV, S_DIGOUT, S_LAST
  } state_t;

  state_t                          state;
  logic [MAX_DIMS-1:0][DIGIT_W-1:0] digits;
  logic                            done;
  logic [MAX_DIMS-1:0][LIN_W-1:0]   strides;
  logic [LIN_W-1:0]                cur;    // running stride product
  logic [LIN_W-1:0]                acc;    // partial product
  logic [LIN_W-1:0]                rem;    // remaining linear index
  logic [DIGIT_W-1:0]              quo;
  logic [BIT_W-1:0]                bitc;
  logic [POS_W-1:0]                idx;
  logic [POS_W-1:0]                dim_j;
  logic                            carry_in;
  logic [ST_W-1:0]                 st;

  logic             res_free;
  logic             res_load;
  logic             is_last;
  logic [DIGIT_W:0] inc;
  logic             wrap;
  logic [LIN_W-1:0] alu_a;
  logic [LIN_W-1:0] alu_b;
  logic [BIT_W-1:0] alu_sh;
  logic             alu_sub;
  logic [LIN_W-1:0] alu_sum;
  logic             alu_carry;
  logic [LIN_W-1:0] acc_next;
  logic [DIGIT_W-1:0] quo_next;

  assign res_free  = !res_valid || !res_stall;
  // result register loads in every output state once it is free
  assign res_load  = res_free && (state == S_STATUS || state == S_NEXT ||
                                  state == S_DIGOUT || state == S_LAST);
  assign cmd_stall = (state != S_IDLE);
  assign is_last   = (({1'b0, idx} + 3'd1) == cfg.n);
  assign inc       = {1'b0, digits[idx]} + {{DIGIT_W{1'b0}}, 1'b1};
  assign wrap      = (inc >= {1'b0, cfg.sizes[idx]});

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sh  = '0;
    alu_sub = 1'b0;
    case (state)
      S_MUL: begin
        alu_a  = acc;
        alu_b  = cur;
        alu_sh = bitc;
      end
      S_RANGE: begin
        alu_a   = rem;
        alu_b   = cur;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = rem;
        alu_b   = strides[idx];
        alu_sh  = bitc;
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  mrii_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sh    (alu_sh),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign acc_next = cfg.sizes[dim_j][bitc] ? alu_sum : acc;

  always_comb begin
    quo_next       = quo;
    quo_next[bitc] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      digits    <= '0;
      done      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            rem      <= cmd.linear_index;
            cur      <= {{(LIN_W-1){1'b0}}, 1'b1};
            acc      <= '0;
            bitc     <= '0;
            idx      <= '0;
            dim_j    <= POS_W'(cfg.n - 3'd1);
            carry_in <= 1'b1;
            if (cmd.opcode == OP_RESTART) begin
              digits <= '0;
              done   <= 1'b0;
            end else if (cmd.opcode == OP_NEXT || cmd.opcode == OP_REVERSE) begin
              if (cfg.zero) begin
                st    <= ST_ZERO_DIM;
                state <= S_STATUS;
              end else if (cmd.opcode == OP_NEXT) begin
                if (done) begin
                  st    <= ST_FINISHED;
                  state <= S_STATUS;
                end else if (cfg.n == '0) begin
                  done  <= 1'b1;
                  st    <= ST_EMPTY;
                  state <= S_STATUS;
                end else begin
                  state <= S_NEXT;
                end
              end else if (cfg.n == '0) begin
                state <= S_RANGE;  // total is 1
              end else begin
                state <= S_MUL;
              end
            end
          end
        end
        S_STATUS: begin
          if (res_free) begin
            res   <= '{position: '0, digit: '0, last: 1'b1, status: st};
            state <= S_IDLE;
          end
        end
        S_NEXT: begin
          if (res_free) begin
            res <= '{position: idx, digit: digits[idx], last: is_last,
                     status: ST_OK};
            if (carry_in) begin
              if (!wrap) begin
                digits[idx] <= inc[DIGIT_W-1:0];
                carry_in    <= 1'b0;
              end else begin
                digits[idx] <= '0;
                if (is_last) begin
                  done <= 1'b1;
                end
              end
            end
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 2'd1;
            end
          end
        end
        S_MUL: begin
          // shift-add multiply of cur by size of dimension dim_j
          if (bitc == BIT_W'(DIGIT_W - 1)) begin
            strides[dim_j] <= cur;
            cur            <= acc_next;
            acc            <= '0;
            bitc           <= '0;
            if (dim_j == '0) begin
              state <= S_RANGE;
            end else begin
              dim_j <= dim_j - 2'd1;
            end
          end else begin
            acc  <= acc_next;
            bitc <= bitc + 1'b1;
          end
        end
        S_RANGE: begin
          bitc <= BIT_W'(DIGIT_W - 1);
          quo  <= '0;
          if (alu_carry) begin
            st    <= ST_RANGE;
            state <= S_STATUS;
          end else if (cfg.n == '0) begin
            st    <= ST_EMPTY;
            state <= S_STATUS;
          end else if (cfg.n == 3'd1) begin
            state <= S_LAST;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (alu_carry) begin
            rem <= alu_sum;
            quo <= quo_next;
          end
          if (bitc == '0) begin
            state <= S_DIGOUT;
          end else begin
            bitc <= bitc - 1'b1;
          end
        end
        S_DIGOUT: begin
          if (res_free) begin
            res  <= '{position: idx, digit: quo, last: 1'b0, status: ST_OK};
            idx  <= idx + 2'd1;
            bitc <= BIT_W'(DIGIT_W - 1);
            quo  <= '0;
            if (({1'b0, idx} + 3'd2) == cfg.n) begin
              state <= S_LAST;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_LAST: begin
          if (res_free) begin
            res   <= '{position: idx, digit: rem[DIGIT_W-1:0], last: 1'b1,
                       status: ST_OK};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/mixed_radix_index_iterator.sv @@
// ----------------------------------------------------------------------------
// mixed_radix_index_iterator: multi-dimensional index iterator
// Odometer walk over configured dimension sizes and linear index decomposition.
// ----------------------------------------------------------------------------
// Restart and the unused opcode return to idle with no result. A status item
//   goes out from the status state; next emits one result per dimension in use.
// Reverse with n >= 1 forms the stride products on the shared shift-add unit,
//   then does the range check, restoring division for n-1 digits and the last
//   digit; out of range or n = 0 ends after the range check. Output stalls hold
//   results. One item at a time; cmd_stall stays high until the item's last result loads.
// Reset (sync, rst high): dim_count 0, sizes 1, digits and finished flag clear.
module mixed_radix_index_iterator
  import mrii_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cmd_t               cmd,
  // result channel
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res,
  // configuration writes
  input  logic               wr_en,
  input  logic [REG_W-1:0]   wr_index,
  input  logic [DIGIT_W-1:0] wr_data
);

  // Configuration registers. Index 0 is the dimension count, indexes 1..4
  // the sizes. Writes to unused indexes are dropped.
  logic [CNT_W-1:0]                 dim_count;
  logic [MAX_DIMS-1:0][DIGIT_W-1:0] dim_size;
  logic [REG_W-1:0]                 size_off;
  logic [POS_W-1:0]                 size_sel;

  assign size_off = wr_index - REG_DIM_SIZE0;
  assign size_sel = size_off[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        dim_size[i] <= DIGIT_W'(1);
      end
    end else if (wr_en) begin
      if (wr_index == REG_DIM_COUNT) begin
        dim_count <= wr_data[CNT_W-1:0];
      end else if (wr_index >= REG_DIM_SIZE0 &&
                   size_off < REG_W'(MAX_DIMS)) begin
        dim_size[size_sel] <= wr_data;
      end
    end
  end

  // Count in use is clipped to MAX_DIMS; a zero size among the used
  // dimensions turns next and reverse into a single status item.
  cfg_view_t cfg;

  always_comb begin
    cfg.n     = (dim_count > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : dim_count;
    cfg.sizes = dim_size;
    cfg.zero  = 1'b0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (CNT_W'(i) < cfg.n && dim_size[i] == '0) begin
        cfg.zero = 1'b1;
      end
    end
  end

  // Sequencer: owns the odometer, the stride table, the shared arithmetic
  // unit and the result register.
  mrii_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
